// ----- design/tsf_pkg.sv -----
// Shared types, constants and divider step functions for the two-input fuzzy block.
package tsf_pkg;

	// Widths of the crisp values and of the membership fraction.
	localparam int VALUE_BITS = 16;
	localparam int FRAC_BITS  = 16;

	// Membership divider: quotient up to ONE, remainder below the divisor.
	localparam int QB   = FRAC_BITS + 1;
	localparam int RB   = VALUE_BITS + 1;
	localparam int NUMW = VALUE_BITS + FRAC_BITS + 1;

	// Strength sum, weighted sum, product and final divider widths.
	localparam int DW   = FRAC_BITS + 3;
	localparam int WW   = 2 * QB + 1;
	localparam int PW   = VALUE_BITS + WW;
	localparam int NW   = PW + 1;
	localparam int MW   = DW + FRAC_BITS;
	localparam int FRW  = MW + 1;
	localparam int FQB  = VALUE_BITS + 1;

	localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;
	localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEMAND_LOW  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEMAND_HIGH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STOCK_LOW   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STOCK_HIGH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_FLOOR   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_SPAN    = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [VALUE_BITS-1:0] RST_DEMAND_LOW  = VALUE_BITS'(1000);
	localparam logic [VALUE_BITS-1:0] RST_DEMAND_HIGH = VALUE_BITS'(5000);
	localparam logic [VALUE_BITS-1:0] RST_STOCK_LOW   = VALUE_BITS'(100);
	localparam logic [VALUE_BITS-1:0] RST_STOCK_HIGH  = VALUE_BITS'(600);
	localparam logic [VALUE_BITS-1:0] RST_OUT_FLOOR   = VALUE_BITS'(2000);
	localparam logic [VALUE_BITS-1:0] RST_OUT_SPAN    = VALUE_BITS'(5000);

	// One lane of the membership divider pipeline.
	typedef struct packed {
		logic [RB-1:0]         r;
		logic [QB-1:0]         lo;
		logic [VALUE_BITS-1:0] d;
		logic [QB-1:0]         q;
		logic                  ovr;
		logic [QB-1:0]         oval;
	} mdiv_t;

	// One stage of the final weighted-average divider.
	typedef struct packed {
		logic [FRW-1:0] r;
		logic [FQB-1:0] lo;
		logic [MW-1:0]  m;
		logic [FQB-1:0] q;
		logic           dz;
	} fdiv_t;

	// Set up a membership lane: clamp cases become overrides, the rest a rounded division.
	function automatic mdiv_t mdiv_entry(input logic [VALUE_BITS-1:0] z,
		input logic [VALUE_BITS-1:0] lo, input logic [VALUE_BITS-1:0] hi, input logic rising);
		mdiv_t                 e;
		logic [VALUE_BITS-1:0] a;
		logic [VALUE_BITS-1:0] d;
		logic [NUMW-1:0]       num;
		e = '0;
		a = '0;
		d = VALUE_BITS'(1);
		if (lo >= hi) begin
			e.ovr  = 1'b1;
			e.oval = ((z >= hi) == rising) ? ONE : '0;
		end else if (z <= lo) begin
			e.ovr  = 1'b1;
			e.oval = rising ? '0 : ONE;
		end else if (z >= hi) begin
			e.ovr  = 1'b1;
			e.oval = rising ? ONE : '0;
		end else begin
			a = rising ? (z - lo) : (hi - z);
			d = hi - lo;
		end
		num  = {1'b0, a, {FRAC_BITS{1'b0}}} + NUMW'(d >> 1);
		e.r  = RB'(num[NUMW-1:QB]);
		e.lo = num[QB-1:0];
		e.d  = d;
		return e;
	endfunction

	// One restoring division step of a membership lane.
	function automatic mdiv_t mdiv_step(input mdiv_t x, input logic b);
		mdiv_t       y;
		logic [RB-1:0] rr;
		y  = x;
		rr = {x.r[RB-2:0], b};
		if (rr >= {1'b0, x.d}) begin
			y.r = rr - {1'b0, x.d};
			y.q = {x.q[QB-2:0], 1'b1};
		end else begin
			y.r = rr;
			y.q = {x.q[QB-2:0], 1'b0};
		end
		return y;
	endfunction

	// One restoring division step of the final divider.
	function automatic fdiv_t fdiv_step(input fdiv_t x, input logic b);
		fdiv_t          y;
		logic [FRW-1:0] rr;
		y  = x;
		rr = {x.r[FRW-2:0], b};
		if (rr >= {1'b0, x.m}) begin
			y.r = rr - {1'b0, x.m};
			y.q = {x.q[FQB-2:0], 1'b1};
		end else begin
			y.r = rr;
			y.q = {x.q[FQB-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

// ----- design/tsukamoto_fuzzy_two_input.sv -----
// Two-input, four-rule Tsukamoto fuzzy inference with a fully pipelined datapath.
//
// Each transaction on the slave stream carries a demand and a stock value; the block returns
// one production value per transaction, in order, on the master stream. A new item is taken
// every clock cycle while the pipeline is not held. An item passes 41 register stages: one
// entry stage, 17 bit-per-stage membership divider stages, four stages of rule strengths,
// products, sums and span scaling, one divider entry stage, 17 bit-per-stage stages of the
// final weighted-average divider and the output register. The whole pipeline holds when the
// output register is full and not taken.
// Configuration registers are to be written only while no item is in flight.
module tsukamoto_fuzzy_two_input import tsf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// Slave stream. tdata: demand [15:0], stock [31:16].
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [2*VALUE_BITS-1:0] s_tdata,
	// Master stream. tdata: production [15:0].
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [VALUE_BITS-1:0]   m_tdata,
	// Configuration write channel.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [VALUE_BITS-1:0]   cfg_data
);

	localparam int NL = 4;

	logic [VALUE_BITS-1:0] dlo_q, dhi_q, slo_q, shi_q, floor_q, span_q;

	logic adv;

	mdiv_t md_s  [NL][0:QB];
	logic  mv_s  [0:QB];
	mdiv_t ent   [NL];

	logic [QB-1:0] mem   [NL];
	logic [QB-1:0] str_s [NL];
	logic          str_v_s;
	logic [2*QB-1:0] prd_s [NL];
	logic [DW-1:0] den_p_s;
	logic          prd_v_s;
	logic [WW-1:0] w_s;
	logic [DW-1:0] den_s;
	logic          sum_v_s;
	logic [PW-1:0] pw_s;
	logic [DW-1:0] den_m_s;
	logic          pw_v_s;

	fdiv_t fd_s [0:FQB];
	logic  fv_s [0:FQB];
	fdiv_t fent;
	logic [NW-1:0] fnum;

	logic [VALUE_BITS+1:0] res;
	logic                  out_v_s;
	logic [VALUE_BITS-1:0] out_s;

	// The whole pipeline moves unless the output register holds an untaken result.
	assign adv       = !out_v_s || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlo_q   <= RST_DEMAND_LOW;
			dhi_q   <= RST_DEMAND_HIGH;
			slo_q   <= RST_STOCK_LOW;
			shi_q   <= RST_STOCK_HIGH;
			floor_q <= RST_OUT_FLOOR;
			span_q  <= RST_OUT_SPAN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEMAND_LOW:  dlo_q   <= cfg_data;
				REG_DEMAND_HIGH: dhi_q   <= cfg_data;
				REG_STOCK_LOW:   slo_q   <= cfg_data;
				REG_STOCK_HIGH:  shi_q   <= cfg_data;
				REG_OUT_FLOOR:   floor_q <= cfg_data;
				REG_OUT_SPAN:    span_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Lane setup: demand falling, demand rising, stock small, stock large.
	always_comb begin
		ent[0] = mdiv_entry(s_tdata[VALUE_BITS-1:0], dlo_q, dhi_q, 1'b0);
		ent[1] = mdiv_entry(s_tdata[VALUE_BITS-1:0], dlo_q, dhi_q, 1'b1);
		ent[2] = mdiv_entry(s_tdata[2*VALUE_BITS-1:VALUE_BITS], slo_q, shi_q, 1'b0);
		ent[3] = mdiv_entry(s_tdata[2*VALUE_BITS-1:VALUE_BITS], slo_q, shi_q, 1'b1);
	end

	// Membership value at the end of each lane.
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			mem[l] = md_s[l][QB].ovr ? md_s[l][QB].oval : md_s[l][QB].q;
		end
	end

	// Final divider setup: round span*W/(D*ONE) by adding half the divisor.
	always_comb begin
		fnum    = NW'(pw_s) + (NW'(den_m_s) << (FRAC_BITS - 1));
		fent.r  = FRW'(fnum[NW-1:FQB]);
		fent.lo = fnum[FQB-1:0];
		fent.m  = MW'(den_m_s) << FRAC_BITS;
		fent.q  = '0;
		fent.dz = (den_m_s == '0);
	end

	// Floor plus increment, saturated.
	assign res = (VALUE_BITS+2)'(floor_q)
		+ (fd_s[FQB].dz ? '0 : (VALUE_BITS+2)'(fd_s[FQB].q));

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) mv_s[k] <= 1'b0;
			for (int k = 0; k <= FQB; k++) fv_s[k] <= 1'b0;
			str_v_s <= 1'b0;
			prd_v_s <= 1'b0;
			sum_v_s <= 1'b0;
			pw_v_s  <= 1'b0;
			out_v_s <= 1'b0;
		end else if (adv) begin
			mv_s[0] <= s_tvalid;
			for (int k = 1; k <= QB; k++) mv_s[k] <= mv_s[k-1];
			str_v_s <= mv_s[QB];
			prd_v_s <= str_v_s;
			sum_v_s <= prd_v_s;
			pw_v_s  <= sum_v_s;
			fv_s[0] <= pw_v_s;
			for (int k = 1; k <= FQB; k++) fv_s[k] <= fv_s[k-1];
			out_v_s <= fv_s[FQB];
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < NL; l++) begin
				md_s[l][0] <= ent[l];
				for (int k = 1; k <= QB; k++) begin
					md_s[l][k] <= mdiv_step(md_s[l][k-1], md_s[l][k-1].lo[QB-k]);
				end
			end
			// Rule strengths.
			str_s[0] <= (mem[0] < mem[3]) ? mem[0] : mem[3];
			str_s[1] <= (mem[0] < mem[2]) ? mem[0] : mem[2];
			str_s[2] <= (mem[1] < mem[3]) ? mem[1] : mem[3];
			str_s[3] <= (mem[1] < mem[2]) ? mem[1] : mem[2];
			// Strength times consequent position.
			prd_s[0] <= (2*QB)'(str_s[0]) * ((2*QB)'(ONE) - (2*QB)'(str_s[0]));
			prd_s[1] <= (2*QB)'(str_s[1]) * ((2*QB)'(ONE) - (2*QB)'(str_s[1]));
			prd_s[2] <= (2*QB)'(str_s[2]) * (2*QB)'(str_s[2]);
			prd_s[3] <= (2*QB)'(str_s[3]) * (2*QB)'(str_s[3]);
			den_p_s  <= DW'(str_s[0]) + DW'(str_s[1]) + DW'(str_s[2]) + DW'(str_s[3]);
			// Weighted sum.
			w_s   <= WW'(prd_s[0]) + WW'(prd_s[1]) + WW'(prd_s[2]) + WW'(prd_s[3]);
			den_s <= den_p_s;
			// Scale by the span.
			pw_s    <= PW'(span_q) * PW'(w_s);
			den_m_s <= den_s;
			fd_s[0] <= fent;
			for (int k = 1; k <= FQB; k++) begin
				fd_s[k] <= fdiv_step(fd_s[k-1], fd_s[k-1].lo[FQB-k]);
			end
			out_s <= (res > (VALUE_BITS+2)'(VMAX)) ? VMAX : res[VALUE_BITS-1:0];
		end
	end

	assign m_tvalid = out_v_s;
	assign m_tdata  = out_s;

	// A stalled pipeline keeps the final divider's last stage unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(fd_s[FQB]) && $stable(fv_s[FQB]))
		else $error("final divider stage changed during a stall");

	// A membership never exceeds one.
	a_mem_range: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s[QB] |-> (mem[0] <= ONE) && (mem[1] <= ONE) && (mem[2] <= ONE) && (mem[3] <= ONE))
		else $error("membership above one");

	// The strength sum is never zero for a live item.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sum_v_s |-> den_s != '0)
		else $error("zero strength sum");

	// The weighted-average increment never exceeds the span by more than rounding.
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		fv_s[FQB] && !fd_s[FQB].dz |-> fd_s[FQB].q <= FQB'(span_q) + FQB'(1))
		else $error("quotient beyond span");

endmodule
